/* rtl/core/ffa_pkg.sv */
// Shared constants, codes and token type for the first-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);

  localparam logic [31:0]      HDR     = 32'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  // configuration register indexes
  localparam logic CFG_HEAP_START = 1'b0;
  localparam logic CFG_HEAP_END   = 1'b1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOHEAP  = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_e;

  // request token handed from cell to cell
  typedef struct packed {
    logic        vld;
    op_e         op;
    logic [31:0] size;      // alloc request size
    logic [31:0] addr;      // free: payload address; alloc: current break
    logic        fit;       // append would stay within heap_end
    logic        done;      // some cell already served the request
    logic        appended;  // served by appending a new block
    logic [31:0] res_addr;  // payload address given out
  } ffa_tok_t;

endpackage

`default_nettype wire

/* rtl/core/ffa_cell.sv */
// One table entry of the allocator chain: holds a block and serves a passing token.
`timescale 1ns / 1ps
`default_nettype none

module ffa_cell import ffa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ffa_tok_t tok_i,
  output ffa_tok_t tok_o
);

  logic        used_q, used_d;   // entry holds a block
  logic        free_q, free_d;
  logic [31:0] pay_q, pay_d;     // payload address (header start + HDR)
  logic [31:0] size_q, size_d;
  logic        vld_q;            // token stage holds a live request
  ffa_tok_t    tok_q, tok_d;

  always_comb begin
    used_d = used_q;
    free_d = free_q;
    pay_d  = pay_q;
    size_d = size_q;
    tok_d  = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      if (used_q) begin
        if (tok_i.op == OP_ALLOC) begin
          if (free_q && (size_q >= tok_i.size)) begin
            free_d         = 1'b0;
            tok_d.done     = 1'b1;
            tok_d.res_addr = pay_q;
          end
        end else if (pay_q == tok_i.addr) begin
          free_d     = 1'b1;
          tok_d.done = 1'b1;
        end
      end else if ((tok_i.op == OP_ALLOC) && tok_i.fit) begin
        // first empty entry: no earlier block fitted, append at the break
        used_d         = 1'b1;
        free_d         = 1'b0;
        pay_d          = tok_i.addr + HDR;
        size_d         = tok_i.size;
        tok_d.done     = 1'b1;
        tok_d.appended = 1'b1;
        tok_d.res_addr = tok_i.addr + HDR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      free_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      used_q <= used_d;
      free_q <= free_d;
      vld_q  <= tok_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q  <= pay_d;
    size_q <= size_d;
    tok_q  <= tok_d;
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end

endmodule

`default_nettype wire

/* rtl/core/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: control, break tracking and cell chain.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_stall_o | operation_i, request_size_i, address_i
//  out     | output    | out_valid_o/out_stall_i | result_address_o, status_o
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// An allocate or free beat walks the chain of MAX_BLOCKS cells, one cell per cycle,
// then passes through the hold stage and into the output register.
// Zero-size allocates and frees of address zero skip the chain and go to the hold stage.
// One beat in flight at a time; the next is accepted while the result waits in the output register.
// Reset clears the table (per-cell used/free bits), block count and break at once.
// Output stalls hold the result register; a finished result waits in a hold stage.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator import ffa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] request_size_i,
  input  logic [31:0] address_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_address_o,
  output logic [2:0]  status_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [31:0]      heap_start_q, heap_end_q;
  logic [31:0]      heap_used_q;
  logic [CNT_W-1:0] blk_cnt_q;

  // hold stage between chain exit and output register
  logic [31:0] hold_addr_q, hold_addr_d;
  status_e     hold_st_q, hold_st_d;

  logic        out_valid_q;
  logic [31:0] out_addr_q;
  status_e     out_st_q;

  ffa_tok_t tok [MAX_BLOCKS+1];
  ffa_tok_t tok_last;

  logic        accept, bypass, launch, exit_vld, out_free, out_load;
  op_e         in_op;
  logic [32:0] brk;
  logic [33:0] nbrk;
  logic        fit;

  assign in_op    = op_e'(operation_i);
  assign accept   = in_valid_i && !in_stall_o;
  // requests answered without a scan
  assign bypass   = (in_op == OP_ALLOC) ? (request_size_i == 32'd0) : (address_i == 32'd0);
  assign launch   = accept && !bypass;
  assign tok_last = tok[MAX_BLOCKS];
  assign exit_vld = tok_last.vld;
  assign out_free = !out_valid_q || !out_stall_i;

  // break and heap limit check, no wrap
  assign brk  = {1'b0, heap_start_q} + {1'b0, heap_used_q};
  assign nbrk = {1'b0, brk} + {2'b00, HDR} + {2'b00, request_size_i};
  assign fit  = (nbrk <= {2'b00, heap_end_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = bypass ? S_HOLD : S_SCAN;
      end
      S_SCAN: begin
        if (exit_vld) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_SCAN:  in_stall_o = 1'b1;
      S_HOLD:  out_load   = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  // hold stage contents
  always_comb begin
    hold_addr_d = hold_addr_q;
    hold_st_d   = hold_st_q;
    if (accept && bypass) begin
      hold_addr_d = 32'd0;
      hold_st_d   = (in_op == OP_ALLOC) ? ST_ZERO : ST_OK;
    end else if (exit_vld) begin
      if (tok_last.done) begin
        hold_st_d   = ST_OK;
        hold_addr_d = (tok_last.op == OP_ALLOC) ? tok_last.res_addr : 32'd0;
      end else begin
        hold_addr_d = 32'd0;
        if (tok_last.op == OP_FREE)      hold_st_d = ST_UNKNOWN;
        else if (blk_cnt_q == CNT_MAX)   hold_st_d = ST_FULL;
        else                             hold_st_d = ST_NOHEAP;
      end
    end
  end

  // token entering the first cell
  assign tok[0] = '{vld:      launch,
                    op:       in_op,
                    size:     request_size_i,
                    addr:     (in_op == OP_FREE) ? address_i : brk[31:0],
                    fit:      fit,
                    done:     1'b0,
                    appended: 1'b0,
                    res_addr: 32'd0};

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      heap_start_q <= 32'd0;
      heap_end_q   <= 32'hFFFF_FFFF;
      heap_used_q  <= 32'd0;
      blk_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HEAP_START: heap_start_q <= cfg_data_i;
          CFG_HEAP_END:   heap_end_q   <= cfg_data_i;
          default:        heap_end_q   <= heap_end_q;
        endcase
      end
      if (exit_vld && tok_last.appended) begin
        blk_cnt_q   <= blk_cnt_q + CNT_W'(1);
        heap_used_q <= heap_used_q + HDR + tok_last.size;
      end
      if (out_load)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_addr_q <= hold_addr_d;
    hold_st_q   <= hold_st_d;
    if (out_load) begin
      out_addr_q <= hold_addr_q;
      out_st_q   <= hold_st_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_st_q;

`ifndef SYNTHESIS
  a_exit_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_vld |-> (state_q == S_SCAN))
    else $error("token left the chain outside a scan");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_cnt_q <= CNT_MAX)
    else $error("block count above table size");

  a_append_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exit_vld && tok_last.appended) |-> (blk_cnt_q != CNT_MAX))
    else $error("append into a full table");

  a_launch_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch |=> (state_q == S_SCAN))
    else $error("scan launched without entering scan state");
`endif

endmodule

`default_nettype wire
